@@ hdl/hsva_pkg.sv @@
// Shared widths, register indexes and divider sizing for the HSV pixel adjuster.
`timescale 1ns / 1ps

package hsva_pkg;

	// Color components are unsigned 16-bit fixed point, 65535 = 1.0.
	localparam int CHAN_W     = 16;
	localparam int PIX_W      = 3 * CHAN_W;
	localparam int DELTA_W    = 17;

	// Configuration port.
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 17;

	localparam logic [CFG_IDX_W-1:0] REG_ADJUST_ENABLE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HUE_SHIFT     = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SAT_DELTA     = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VAL_DELTA     = 8'd3;

	// Hue numerator reaches 6 * chroma, which needs 19 bits.
	localparam int HUE_NUM_W  = 19;

	// Pipelined restoring divider: quotient bits, bits per stage, stages.
	localparam int DIV_QW     = 18;
	localparam int DIV_BPS    = 3;
	localparam int DIV_NS     = DIV_QW / DIV_BPS;

	// Back conversion scale 65535 * 65536 and its rounding half.
	localparam logic [31:0] K_FULL = 32'hFFFF_0000;
	localparam logic [47:0] K_HALF = 48'h0000_7FFF_8000;
	localparam logic [31:0] P_HALF = 32'd32767;

endpackage

@@ hdl/hsva_div.sv @@
// Pipelined restoring divider, a fixed number of quotient bits per stage.
`timescale 1ns / 1ps

module hsva_div #(
	parameter int DW  = hsva_pkg::CHAN_W,
	parameter int QW  = hsva_pkg::DIV_QW,
	parameter int BPS = hsva_pkg::DIV_BPS,
	localparam int NS = QW / BPS,
	localparam int WW = DW + QW
) (
	input  logic          clk,
	input  logic [NS-1:0] en,
	input  logic [WW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic [QW-1:0] quotient
);

	// The upper DW bits of the dividend must be below the divisor, so the
	// quotient fits in QW bits.
	function automatic logic [WW-1:0] div_step(input logic [WW-1:0] w,
	                                           input logic [DW-1:0] dv);
		logic [DW:0] trial;
		logic [DW:0] diff;
		trial = w[WW-1:QW-1];
		diff  = trial - {1'b0, dv};
		if (trial >= {1'b0, dv}) begin
			div_step = {diff[DW-1:0], w[QW-2:0], 1'b1};
		end else begin
			div_step = {trial[DW-1:0], w[QW-2:0], 1'b0};
		end
	endfunction

	logic [WW-1:0] w_s  [NS];
	logic [DW-1:0] dv_s [NS-1];

	for (genvar k = 0; k < NS; k++) begin : g_stage
		logic [WW-1:0] w_in;
		logic [WW-1:0] w_nxt;
		logic [DW-1:0] dv_in;

		if (k == 0) begin : g_first
			assign w_in  = dividend;
			assign dv_in = divisor;
		end else begin : g_next
			assign w_in  = w_s[k-1];
			assign dv_in = dv_s[k-1];
		end

		always_comb begin
			w_nxt = w_in;
			for (int i = 0; i < BPS; i++) begin
				w_nxt = div_step(w_nxt, dv_in);
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				w_s[k] <= w_nxt;
			end
		end

		if (k < NS - 1) begin : g_dv
			always_ff @(posedge clk) begin
				if (en[k]) begin
					dv_s[k] <= dv_in;
				end
			end
		end
	end

	assign quotient = w_s[NS-1][QW-1:0];

endmodule

@@ hdl/hsv_pixel_adjust_top.sv @@
// Top level of the HSV hue, saturation and value adjuster for RGB pixel streams.
`timescale 1ns / 1ps

// Usage:
// Pixels enter on the s_ stream channel (red, green, blue in s_tdata, the
// end-of-image flag in s_tlast) and leave on the m_ channel in the same
// format, one result per pixel and in order. The cfg channel writes the
// enable, hue shift, saturation delta and value delta registers; cfg_ready
// is always high, and writes belong to times when no pixel is in flight.
// The datapath is 13 register stages deep, from the input register to the
// output register. The two dividers (saturation and hue), which resolve three
// quotient bits per stage over six stages, make up six of those stages. One
// pixel per clock is sustained while m_tready stays high. When the receiver
// stalls, a full stage holds only while every stage after it is full too, so
// empty slots close up and s_tready drops only once all 13 stages hold a
// pixel. Reset clears every valid bit and sets all configuration registers
// to zero, which passes pixels through unchanged.
module hsv_pixel_adjust_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [hsva_pkg::PIX_W-1:0]          s_tdata,   // red_in, green_in, blue_in
	input  logic                                s_tlast,   // last_pixel_in
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [hsva_pkg::PIX_W-1:0]          m_tdata,   // red_out, green_out, blue_out
	output logic                                m_tlast,   // last_pixel_out
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [hsva_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [hsva_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int CW      = hsva_pkg::CHAN_W;
	localparam int NW      = hsva_pkg::HUE_NUM_W;
	localparam int QW      = hsva_pkg::DIV_QW;
	localparam int DNS     = hsva_pkg::DIV_NS;
	localparam int ST_DIV0 = 3;
	localparam int ST_DIVL = 2 + DNS;
	localparam int ST_ADJ  = ST_DIVL + 1;
	localparam int ST_MUL  = ST_DIVL + 2;
	localparam int ST_PRD  = ST_DIVL + 3;
	localparam int ST_RND  = ST_DIVL + 4;
	localparam int NSTG    = ST_DIVL + 5;

	// Hue sextants, from red toward yellow and on around the wheel.
	localparam logic [2:0] SX_RED_YEL = 3'd0;
	localparam logic [2:0] SX_YEL_GRN = 3'd1;
	localparam logic [2:0] SX_GRN_CYN = 3'd2;
	localparam logic [2:0] SX_CYN_BLU = 3'd3;
	localparam logic [2:0] SX_BLU_MAG = 3'd4;

	typedef struct packed {
		logic [CW-1:0] blue;
		logic [CW-1:0] green;
		logic [CW-1:0] red;
		logic          last;
	} pix_t;

	typedef struct packed {
		pix_t          pix;
		logic [CW-1:0] val;
		logic          val_zero;
		logic          chroma_zero;
	} side_t;

	function automatic logic [CW-1:0] clamp16(input logic signed [CW+2:0] x);
		if (x < 0) begin
			clamp16 = '0;
		end else if (x > $signed({3'b000, {CW{1'b1}}})) begin
			clamp16 = '1;
		end else begin
			clamp16 = x[CW-1:0];
		end
	endfunction

	// floor(y / 65535): y = hi*65535 + (hi + lo), and hi + lo is at most 2*65535.
	function automatic logic [CW-1:0] div65535(input logic [2*CW-1:0] y);
		logic [CW:0] s;
		logic [CW:0] q;
		s = {1'b0, y[2*CW-1:CW]} + {1'b0, y[CW-1:0]};
		q = {1'b0, y[2*CW-1:CW]};
		if (s >= {{CW{1'b1}}, 1'b0}) begin
			q = q + (CW+1)'(2);
		end else if (s >= {1'b0, {CW{1'b1}}}) begin
			q = q + (CW+1)'(1);
		end
		div65535 = q[CW-1:0];
	endfunction

	// ---------------- configuration ----------------
	logic                           adjust_enable_q;
	logic [CW-1:0]                  hue_shift_q;
	logic [hsva_pkg::DELTA_W-1:0]   sat_delta_q;
	logic [hsva_pkg::DELTA_W-1:0]   val_delta_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adjust_enable_q <= 1'b0;
			hue_shift_q     <= '0;
			sat_delta_q     <= '0;
			val_delta_q     <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				hsva_pkg::REG_ADJUST_ENABLE: adjust_enable_q <= cfg_data[0];
				hsva_pkg::REG_HUE_SHIFT:     hue_shift_q     <= cfg_data[CW-1:0];
				hsva_pkg::REG_SAT_DELTA:     sat_delta_q     <= cfg_data;
				hsva_pkg::REG_VAL_DELTA:     val_delta_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- pipeline control ----------------
	logic [NSTG:1] vld_s;
	logic [NSTG:1] en;

	// A stage loads when it is empty or the stage after it moves on.
	always_comb begin
		en[NSTG] = !vld_s[NSTG] || m_tready;
		for (int k = NSTG - 1; k >= 1; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[1]) begin
				vld_s[1] <= s_tvalid;
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (en[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	assign s_tready = en[1];
	assign m_tvalid = vld_s[NSTG];

	// ---------------- stage 1: input register ----------------
	pix_t pix_s1;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			pix_s1 <= {s_tdata, s_tlast};
		end
	end

	// Max, min, chroma and hue numerator.
	logic [CW-1:0] mx;
	logic [CW-1:0] mn;
	logic [CW-1:0] chroma;
	logic [NW-1:0] six_d1;
	logic [NW-1:0] num;

	always_comb begin
		mx = pix_s1.red;
		mn = pix_s1.red;
		if (pix_s1.green > mx) mx = pix_s1.green;
		if (pix_s1.blue > mx)  mx = pix_s1.blue;
		if (pix_s1.green < mn) mn = pix_s1.green;
		if (pix_s1.blue < mn)  mn = pix_s1.blue;
		chroma = mx - mn;
		six_d1 = {1'b0, chroma, 2'b00} + {2'b00, chroma, 1'b0};
		// The numerator always lands in 0 .. 6*chroma, so modular sums are exact.
		if (mx == pix_s1.red) begin
			num = {3'b000, pix_s1.green} - {3'b000, pix_s1.blue};
			if (pix_s1.green < pix_s1.blue) begin
				num = num + six_d1;
			end
		end else if (mx == pix_s1.green) begin
			num = {3'b000, pix_s1.blue} - {3'b000, pix_s1.red} +
			      {2'b00, chroma, 1'b0};
		end else begin
			num = {3'b000, pix_s1.red} - {3'b000, pix_s1.green} +
			      {1'b0, chroma, 2'b00};
		end
	end

	// ---------------- stage 2 ----------------
	pix_t          pix_s2;
	logic [CW-1:0] val_s2;
	logic [CW-1:0] chroma_s2;
	logic [NW-1:0] num_s2;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			pix_s2    <= pix_s1;
			val_s2    <= mx;
			chroma_s2 <= chroma;
			num_s2    <= num;
		end
	end

	// Divider operands: saturation = (D*65535 + V/2) / V,
	// hue = (num*65536 + 3D) / 6D.
	logic [CW+QW-1:0] sat_dvd;
	logic [NW+QW-1:0] hue_dvd;
	logic [NW-1:0]    hue_dvs;
	logic [CW+1:0]    three_d;

	always_comb begin
		sat_dvd = {2'b00, chroma_s2, {CW{1'b0}}} - {{(QW){1'b0}}, chroma_s2} +
		          {{(QW+1){1'b0}}, val_s2[CW-1:1]};
		three_d = {1'b0, chroma_s2, 1'b0} + {2'b00, chroma_s2};
		hue_dvd = {2'b00, num_s2, {CW{1'b0}}} + {{(NW+QW-CW-2){1'b0}}, three_d};
		hue_dvs = {1'b0, chroma_s2, 2'b00} + {2'b00, chroma_s2, 1'b0};
	end

	// ---------------- divider stages ----------------
	logic [QW-1:0] sat_q;
	logic [QW-1:0] hue_q;
	side_t         side_s [DNS];

	hsva_div #(
		.DW  (CW),
		.QW  (QW),
		.BPS (hsva_pkg::DIV_BPS)
	) u_sat_div (
		.clk      (clk),
		.en       (en[ST_DIVL:ST_DIV0]),
		.dividend (sat_dvd),
		.divisor  (val_s2),
		.quotient (sat_q)
	);

	hsva_div #(
		.DW  (NW),
		.QW  (QW),
		.BPS (hsva_pkg::DIV_BPS)
	) u_hue_div (
		.clk      (clk),
		.en       (en[ST_DIVL:ST_DIV0]),
		.dividend (hue_dvd),
		.divisor  (hue_dvs),
		.quotient (hue_q)
	);

	always_ff @(posedge clk) begin
		if (en[ST_DIV0]) begin
			side_s[0] <= '{pix: pix_s2, val: val_s2, val_zero: (val_s2 == '0),
			               chroma_zero: (chroma_s2 == '0)};
		end
		for (int k = 1; k < DNS; k++) begin
			if (en[ST_DIV0 + k]) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	// Apply the shift and the clamped deltas.
	logic [CW-1:0]          sat;
	logic [CW-1:0]          hue;
	logic signed [CW+2:0]   sat_sum;
	logic signed [CW+2:0]   val_sum;

	always_comb begin
		sat = side_s[DNS-1].val_zero ? '0 : sat_q[CW-1:0];
		hue = side_s[DNS-1].chroma_zero ? '0 : hue_q[CW-1:0];
		sat_sum = $signed({3'b000, sat}) +
		          $signed({{2{sat_delta_q[hsva_pkg::DELTA_W-1]}}, sat_delta_q});
		val_sum = $signed({3'b000, side_s[DNS-1].val}) +
		          $signed({{2{val_delta_q[hsva_pkg::DELTA_W-1]}}, val_delta_q});
	end

	// ---------------- stage 9: adjusted HSV ----------------
	pix_t          pix_s9;
	logic [CW-1:0] hs_s9;
	logic [CW-1:0] ss_s9;
	logic [CW-1:0] vs_s9;

	always_ff @(posedge clk) begin
		if (en[ST_ADJ]) begin
			pix_s9 <= side_s[DNS-1].pix;
			hs_s9  <= hue + hue_shift_q;
			ss_s9  <= clamp16(sat_sum);
			vs_s9  <= clamp16(val_sum);
		end
	end

	// Sextant, fraction and the two scaled saturation terms.
	logic [CW+2:0]   x6;
	logic [CW-1:0]   frac;
	logic [CW:0]     inv_frac;
	logic [2*CW-1:0] fs;
	logic [2*CW:0]   gs;

	always_comb begin
		x6       = {1'b0, hs_s9, 2'b00} + {2'b00, hs_s9, 1'b0};
		frac     = x6[CW-1:0];
		inv_frac = {1'b1, {CW{1'b0}}} - {1'b0, frac};
		fs       = frac * ss_s9;
		gs       = inv_frac * ss_s9;
	end

	// ---------------- stage 10 ----------------
	pix_t            pix_s10;
	logic [CW-1:0]   vs_s10;
	logic [2:0]      sext_s10;
	logic            grey_s10;
	logic [2*CW-1:0] fa_s10;
	logic [2*CW-1:0] fb_s10;
	logic [CW-1:0]   fc_s10;

	always_ff @(posedge clk) begin
		if (en[ST_MUL]) begin
			pix_s10  <= pix_s9;
			vs_s10   <= vs_s9;
			sext_s10 <= x6[CW+2:CW];
			grey_s10 <= (ss_s9 == '0);
			fa_s10   <= hsva_pkg::K_FULL - fs;
			fb_s10   <= hsva_pkg::K_FULL - gs[2*CW-1:0];
			fc_s10   <= {CW{1'b1}} - ss_s9;
		end
	end

	// ---------------- stage 11: products ----------------
	pix_t            pix_s11;
	logic [CW-1:0]   vs_s11;
	logic [2:0]      sext_s11;
	logic            grey_s11;
	logic [3*CW-1:0] pa_s11;
	logic [3*CW-1:0] pb_s11;
	logic [2*CW-1:0] pc_s11;

	always_ff @(posedge clk) begin
		if (en[ST_PRD]) begin
			pix_s11  <= pix_s10;
			vs_s11   <= vs_s10;
			sext_s11 <= sext_s10;
			grey_s11 <= grey_s10;
			pa_s11   <= vs_s10 * fa_s10;
			pb_s11   <= vs_s10 * fb_s10;
			pc_s11   <= vs_s10 * fc_s10;
		end
	end

	// Round half up; dividing by 65536*65535 starts with dropping 16 bits.
	logic [3*CW-1:0] ra;
	logic [3*CW-1:0] rb;

	always_comb begin
		ra = pa_s11 + hsva_pkg::K_HALF;
		rb = pb_s11 + hsva_pkg::K_HALF;
	end

	// ---------------- stage 12 ----------------
	pix_t            pix_s12;
	logic [CW-1:0]   vs_s12;
	logic [2:0]      sext_s12;
	logic            grey_s12;
	logic [2*CW-1:0] ya_s12;
	logic [2*CW-1:0] yb_s12;
	logic [2*CW-1:0] yc_s12;

	always_ff @(posedge clk) begin
		if (en[ST_RND]) begin
			pix_s12  <= pix_s11;
			vs_s12   <= vs_s11;
			sext_s12 <= sext_s11;
			grey_s12 <= grey_s11;
			ya_s12   <= ra[3*CW-1:CW];
			yb_s12   <= rb[3*CW-1:CW];
			yc_s12   <= pc_s11 + hsva_pkg::P_HALF;
		end
	end

	logic [CW-1:0] q_val;
	logic [CW-1:0] t_val;
	logic [CW-1:0] p_val;
	pix_t          res;

	always_comb begin
		q_val = div65535(ya_s12);
		t_val = div65535(yb_s12);
		p_val = div65535(yc_s12);
		res   = pix_s12;
		if (adjust_enable_q) begin
			if (grey_s12) begin
				res.red   = vs_s12;
				res.green = vs_s12;
				res.blue  = vs_s12;
			end else begin
				case (sext_s12)
					SX_RED_YEL: begin
						res.red = vs_s12; res.green = t_val;  res.blue = p_val;
					end
					SX_YEL_GRN: begin
						res.red = q_val;  res.green = vs_s12; res.blue = p_val;
					end
					SX_GRN_CYN: begin
						res.red = p_val;  res.green = vs_s12; res.blue = t_val;
					end
					SX_CYN_BLU: begin
						res.red = p_val;  res.green = q_val;  res.blue = vs_s12;
					end
					SX_BLU_MAG: begin
						res.red = t_val;  res.green = p_val;  res.blue = vs_s12;
					end
					default: begin
						res.red = vs_s12; res.green = p_val;  res.blue = q_val;
					end
				endcase
			end
		end
	end

	// ---------------- stage 13: output register ----------------
	pix_t pix_s13;

	always_ff @(posedge clk) begin
		if (en[NSTG]) begin
			pix_s13 <= res;
		end
	end

	assign m_tdata = {pix_s13.blue, pix_s13.green, pix_s13.red};
	assign m_tlast = pix_s13.last;

	// ---------------- assertions ----------------
	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (vld_s == '1))
		else $error("input stalled while the pipeline has an empty stage");

	a_sat_quotient_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[ST_DIVL] && !side_s[DNS-1].val_zero |-> (sat_q[QW-1:CW] == '0))
		else $error("saturation quotient above full scale");

	a_hue_quotient_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[ST_DIVL] && !side_s[DNS-1].chroma_zero |->
		(hue_q <= {{(QW-CW-1){1'b0}}, 1'b1, {CW{1'b0}}}))
		else $error("hue quotient beyond one turn");

	a_grey_output: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[ST_RND] && en[NSTG] && adjust_enable_q && grey_s12 |=>
		(pix_s13.red == pix_s13.green) && (pix_s13.green == pix_s13.blue))
		else $error("zero saturation did not give a grey pixel");

endmodule

@@ tb/hsv_pixel_adjust_top_tb.sv @@
// Self-checking testbench for the HSV pixel adjuster with a cycle-free pixel predictor.
`timescale 1ns / 1ps

module hsv_pixel_adjust_top_tb;

	localparam int      HALF_PERIOD   = 10;
	localparam int      RESET_CYCLES  = 12;
	localparam int      PIPE_DRAIN    = 20;
	localparam int      HOLD_CYCLES   = 200;
	localparam int      IDLE_LIMIT    = 5000;
	localparam int      NUM_DIRECTED  = 23;
	localparam int      NUM_PHASES    = 10;
	localparam int      PHASE_PIXELS  = 170;
	localparam longint  K_SCALE       = 64'd65535 * 64'd65536;

	typedef struct packed {
		logic [hsva_pkg::CHAN_W-1:0] red;
		logic [hsva_pkg::CHAN_W-1:0] green;
		logic [hsva_pkg::CHAN_W-1:0] blue;
		logic                        last;
	} pixel_t;

	typedef struct packed {
		logic                         en;
		logic [hsva_pkg::CHAN_W-1:0]  hue;
		logic [hsva_pkg::DELTA_W-1:0] sat;
		logic [hsva_pkg::DELTA_W-1:0] val;
		pixel_t                       px;
		logic                         typed;
		pixel_t                       want;
	} directed_row_t;

	logic                            clk;
	logic                            arst_n;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [hsva_pkg::PIX_W-1:0]      s_tdata;   // red_in, green_in, blue_in
	logic                            s_tlast;   // last_pixel_in
	logic                            m_tvalid;
	logic                            m_tready;
	logic [hsva_pkg::PIX_W-1:0]      m_tdata;   // red_out, green_out, blue_out
	logic                            m_tlast;   // last_pixel_out
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [hsva_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [hsva_pkg::CFG_DATA_W-1:0] cfg_data;

	// Register values as the block should hold them.
	logic                         adj_enable;
	logic [hsva_pkg::CHAN_W-1:0]  adj_hue;
	logic [hsva_pkg::DELTA_W-1:0] adj_sat;
	logic [hsva_pkg::DELTA_W-1:0] adj_val;

	pixel_t        pending_pixels[$];
	directed_row_t directed_rows [NUM_DIRECTED];
	int            fail_count;
	int            result_count;
	int            sent_count;
	int            hold_at;
	int            idle_cycles;
	bit            hold_req;
	bit            tx_gaps_on;
	bit            rx_gaps_on;

	hsv_pixel_adjust_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	function automatic pixel_t pix(input logic [15:0] r, input logic [15:0] g,
			input logic [15:0] b, input logic l);
		pixel_t px;
		px.red = r;
		px.green = g;
		px.blue = b;
		px.last = l;
		return px;
	endfunction

	function automatic longint clamp_unit(input longint x);
		if (x < 0)
			return 0;
		if (x > 65535)
			return 65535;
		return x;
	endfunction

	function automatic pixel_t hsv_adjust_pixel(input pixel_t px);
		longint r, g, b, mx, mn, d, num, hue, sat, hs, ss, vs, x6, f, p, q, t;
		pixel_t res;
		res = px;
		if (!adj_enable)
			return res;
		r = longint'(px.red);
		g = longint'(px.green);
		b = longint'(px.blue);
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		d = mx - mn;
		sat = 0;
		hue = 0;
		if (mx != 0)
			sat = (d * 65535 + mx / 2) / mx;
		if (d != 0) begin
			// Red wins ties over green, and green over blue.
			if (mx == r)
				num = g - b + ((g < b) ? 6 * d : 0);
			else if (mx == g)
				num = b - r + 2 * d;
			else
				num = r - g + 4 * d;
			hue = ((num * 65536 + 3 * d) / (6 * d)) & 65535;
		end
		hs = (hue + longint'(adj_hue)) & 65535;
		ss = clamp_unit(sat + longint'($signed(adj_sat)));
		vs = clamp_unit(mx + longint'($signed(adj_val)));
		if (ss == 0) begin
			res.red = vs[15:0];
			res.green = vs[15:0];
			res.blue = vs[15:0];
			return res;
		end
		x6 = hs * 6;
		f = x6 & 65535;
		p = (vs * (65535 - ss) + 32767) / 65535;
		q = (vs * (K_SCALE - f * ss) + K_SCALE / 2) / K_SCALE;
		t = (vs * (K_SCALE - (65536 - f) * ss) + K_SCALE / 2) / K_SCALE;
		case (x6 >> 16)
			0: begin res.red = vs[15:0]; res.green = t[15:0];  res.blue = p[15:0];  end
			1: begin res.red = q[15:0];  res.green = vs[15:0]; res.blue = p[15:0];  end
			2: begin res.red = p[15:0];  res.green = vs[15:0]; res.blue = t[15:0];  end
			3: begin res.red = p[15:0];  res.green = q[15:0];  res.blue = vs[15:0]; end
			4: begin res.red = t[15:0];  res.green = p[15:0];  res.blue = vs[15:0]; end
			default: begin res.red = vs[15:0]; res.green = p[15:0]; res.blue = q[15:0]; end
		endcase
		return res;
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int sel;
		sel = int'($urandom_range(0, 99));
		if (sel < 80)
			return int'($urandom_range(1, 3));
		if (sel < 95)
			return int'($urandom_range(4, 10));
		return int'($urandom_range(20, 40));
	endfunction

	function automatic logic [hsva_pkg::DELTA_W-1:0] random_delta();
		int v;
		case ($urandom_range(0, 5))
			0: return 17'h10000;
			1: return 17'h10001;
			2: return 17'h00000;
			3: return 17'h0FFFF;
			default: begin
				v = int'($urandom_range(0, 131070)) - 65535;
				return v[hsva_pkg::DELTA_W-1:0];
			end
		endcase
	endfunction

	function automatic logic [hsva_pkg::CHAN_W-1:0] random_hue();
		case ($urandom_range(0, 4))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic pixel_t random_pixel();
		pixel_t px;
		logic [15:0] a;
		px = pix(16'($urandom), 16'($urandom), 16'($urandom), $urandom_range(0, 7) == 0);
		a = 16'($urandom);
		case ($urandom_range(0, 9))
			0: begin px.red = a; px.green = a; px.blue = a; end
			1: px.green = px.red;
			2: px.blue = px.red;
			3: px.blue = px.green;
			4: begin
				px.red = 16'($urandom_range(0, 15));
				px.green = 16'($urandom_range(0, 15));
				px.blue = 16'($urandom_range(0, 15));
			end
			5: begin
				px.red = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
				px.green = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
				px.blue = $urandom_range(0, 1) ? 16'hFFFF : a;
			end
			default: ;
		endcase
		return px;
	endfunction

	task automatic write_reg(input logic [hsva_pkg::CFG_IDX_W-1:0] idx,
			input logic [hsva_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			hsva_pkg::REG_ADJUST_ENABLE: adj_enable = data[0];
			hsva_pkg::REG_HUE_SHIFT:     adj_hue = data[hsva_pkg::CHAN_W-1:0];
			hsva_pkg::REG_SAT_DELTA:     adj_sat = data;
			hsva_pkg::REG_VAL_DELTA:     adj_val = data;
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Writes all four registers, then one random unused index that must be ignored.
	task automatic apply_settings(input logic en, input logic [hsva_pkg::CHAN_W-1:0] hue,
			input logic [hsva_pkg::DELTA_W-1:0] sat, input logic [hsva_pkg::DELTA_W-1:0] val);
		write_reg(hsva_pkg::REG_ADJUST_ENABLE, {16'($urandom), en});
		write_reg(hsva_pkg::REG_HUE_SHIFT, {1'($urandom), hue});
		write_reg(hsva_pkg::REG_SAT_DELTA, sat);
		write_reg(hsva_pkg::REG_VAL_DELTA, val);
		write_reg(8'($urandom_range(4, 255)), 17'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_pixel(input pixel_t px, input logic typed, input pixel_t want);
		int gap;
		gap = (tx_gaps_on && $urandom_range(0, 99) < 25) ? pick_gap() : 0;
		repeat (gap) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {px.blue, px.green, px.red};
		s_tlast <= px.last;
		do @(posedge clk); while (!s_tready);
		pending_pixels.push_back(typed ? want : hsv_adjust_pixel(px));
		sent_count++;
		if (sent_count == hold_at)
			hold_req = 1'b1;
		@(negedge clk);
	endtask

	// Stops offering pixels and waits until the pipeline is empty.
	task automatic drain_pipeline();
		s_tvalid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(negedge clk);
		repeat (PIPE_DRAIN) @(negedge clk);
	endtask

	initial begin
		directed_rows = '{
			// Pass-through after reset.
			'{1'b0, 16'h0000, 17'h00000, 17'h00000, pix(16'h0000, 16'h0000, 16'h0000, 1'b0),
				1'b1, pix(16'h0000, 16'h0000, 16'h0000, 1'b0)},
			'{1'b0, 16'h0000, 17'h00000, 17'h00000, pix(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1),
				1'b1, pix(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1)},
			'{1'b0, 16'h0000, 17'h00000, 17'h00000, pix(16'h1234, 16'hABCD, 16'h5555, 1'b0),
				1'b1, pix(16'h1234, 16'hABCD, 16'h5555, 1'b0)},
			'{1'b0, 16'h0000, 17'h00000, 17'h00000, pix(16'hFFFF, 16'h0000, 16'h8001, 1'b1),
				1'b1, pix(16'hFFFF, 16'h0000, 16'h8001, 1'b1)},
			// Adjustment on with no offsets: black, white, grey and pure red come back as they are.
			'{1'b1, 16'h0000, 17'h00000, 17'h00000, pix(16'h0000, 16'h0000, 16'h0000, 1'b0),
				1'b1, pix(16'h0000, 16'h0000, 16'h0000, 1'b0)},
			'{1'b1, 16'h0000, 17'h00000, 17'h00000, pix(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1),
				1'b1, pix(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1)},
			'{1'b1, 16'h0000, 17'h00000, 17'h00000, pix(16'h8000, 16'h8000, 16'h8000, 1'b0),
				1'b1, pix(16'h8000, 16'h8000, 16'h8000, 1'b0)},
			'{1'b1, 16'h0000, 17'h00000, 17'h00000, pix(16'hFFFF, 16'h0000, 16'h0000, 1'b0),
				1'b1, pix(16'hFFFF, 16'h0000, 16'h0000, 1'b0)},
			'{1'b1, 16'h0000, 17'h00000, 17'h00000, pix(16'h0000, 16'hFFFF, 16'h0000, 1'b0),
				1'b0, '0},
			'{1'b1, 16'h0000, 17'h00000, 17'h00000, pix(16'h0000, 16'h0000, 16'hFFFF, 1'b1),
				1'b0, '0},
			'{1'b1, 16'h0000, 17'h00000, 17'h00000, pix(16'hFFFF, 16'h0000, 16'h0001, 1'b0),
				1'b0, '0},
			'{1'b1, 16'h0000, 17'h00000, 17'h00000, pix(16'hFFFF, 16'hFFFF, 16'h0000, 1'b0),
				1'b0, '0},
			'{1'b1, 16'h0000, 17'h00000, 17'h00000, pix(16'h0001, 16'h0000, 16'h0000, 1'b1),
				1'b0, '0},
			// Half-turn hue shift.
			'{1'b1, 16'h8000, 17'h00000, 17'h00000, pix(16'hFFFF, 16'h0000, 16'h0000, 1'b0),
				1'b0, '0},
			'{1'b1, 16'h8000, 17'h00000, 17'h00000, pix(16'h3000, 16'h9000, 16'hC000, 1'b0),
				1'b0, '0},
			// Saturation forced to zero and value to full scale: white out.
			'{1'b1, 16'hFFFF, 17'h10000, 17'h0FFFF, pix(16'h1234, 16'h0000, 16'hFFFF, 1'b0),
				1'b1, pix(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0)},
			'{1'b1, 16'hFFFF, 17'h10000, 17'h0FFFF, pix(16'h0000, 16'h0000, 16'h0000, 1'b1),
				1'b1, pix(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1)},
			// Value forced to zero: everything turns black. The last four rows use other settings.
			'{1'b1, 16'h8000, 17'h0FFFF, 17'h10000, pix(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0),
				1'b1, pix(16'h0000, 16'h0000, 16'h0000, 1'b0)},
			'{1'b1, 16'h8000, 17'h0FFFF, 17'h10000, pix(16'h4321, 16'h8765, 16'h0ABC, 1'b1),
				1'b1, pix(16'h0000, 16'h0000, 16'h0000, 1'b1)},
			'{1'b1, 16'h0001, 17'h1FFFF, 17'h00001, pix(16'h8000, 16'h4000, 16'h2000, 1'b0),
				1'b0, '0},
			'{1'b1, 16'h0001, 17'h1FFFF, 17'h00001, pix(16'hFFFF, 16'hFFFF, 16'hFFFE, 1'b0),
				1'b0, '0},
			'{1'b1, 16'h5555, 17'h10001, 17'h10001, pix(16'hABCD, 16'h1234, 16'hFFFF, 1'b0),
				1'b0, '0},
			'{1'b1, 16'h5555, 17'h10001, 17'h10001, pix(16'h0000, 16'hFFFF, 16'hFFFF, 1'b1),
				1'b0, '0}
		};

		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		adj_enable = 1'b0;
		adj_hue = '0;
		adj_sat = '0;
		adj_val = '0;
		fail_count = 0;
		sent_count = 0;
		hold_at = -1;
		hold_req = 1'b0;
		tx_gaps_on = 1'b1;
		rx_gaps_on = 1'b1;
		arst_n = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].en !== adj_enable || directed_rows[i].hue !== adj_hue ||
					directed_rows[i].sat !== adj_sat || directed_rows[i].val !== adj_val) begin
				drain_pipeline();
				apply_settings(directed_rows[i].en, directed_rows[i].hue,
					directed_rows[i].sat, directed_rows[i].val);
			end
			send_pixel(directed_rows[i].px, directed_rows[i].typed, directed_rows[i].want);
		end

		// The receiver holds off for a long stretch early in the third random phase.
		hold_at = sent_count + 2 * PHASE_PIXELS + 30;
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain_pipeline();
			apply_settings($urandom_range(0, 9) != 0, random_hue(), random_delta(),
				random_delta());
			tx_gaps_on = (ph % 4 != 1) && (ph != 2);
			rx_gaps_on = (ph % 4 != 3);
			for (int n = 0; n < PHASE_PIXELS; n++)
				send_pixel(random_pixel(), 1'b0, '0);
		end

		drain_pipeline();
		if (fail_count == 0)
			$display("hsv_pixel_adjust_top verification clean");
		else
			$display("hsv_pixel_adjust_top verification failed");
		$finish;
	end

	// Receiver: random stalls, plus the long hold-off when requested.
	initial begin
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (rx_gaps_on && $urandom_range(0, 99) < 20) begin
				m_tready <= 1'b0;
				stall_left = pick_gap() - 1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		pixel_t got;
		pixel_t want;
		got = pix(m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tlast);
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_pixels.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("pixel %0d: unexpected transfer r %h g %h b %h last %b",
						result_count, got.red, got.green, got.blue, got.last);
			end else begin
				want = pending_pixels.pop_front();
				if (got.red !== want.red || got.green !== want.green ||
						got.blue !== want.blue || got.last !== want.last) begin
					fail_count++;
					if (fail_count <= 10)
						$display({"pixel %0d: expected r %h g %h b %h last %b, ",
							"got r %h g %h b %h last %b"},
							result_count, want.red, want.green, want.blue, want.last,
							got.red, got.green, got.blue, got.last);
				end
			end
			result_count++;
		end
	end

	initial result_count = 0;

	// Watchdog on cycles with no transfer on any channel.
	initial idle_cycles = 0;
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("hsv_pixel_adjust_top verification failed");
			$finish;
		end
	end

endmodule
